// ===== sv/accel_activity_level_classifier_macros.svh =====
// ----------------------------------------------------------------------------
// Activity level classifier assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef ACCEL_ACTIVITY_LEVEL_CLASSIFIER_MACROS_SVH
`define ACCEL_ACTIVITY_LEVEL_CLASSIFIER_MACROS_SVH

// same-cycle implication
`define AALC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AALC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/aalc_pkg.sv =====
// ----------------------------------------------------------------------------
// Activity level classifier package
// Shared types, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aalc_pkg;

  localparam int unsigned MaxWindowSamplesDef = 1024;

  localparam int unsigned AxisW  = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned BaseW  = 25;
  localparam int unsigned MagW   = 16;
  localparam int unsigned MacAW  = 25;
  localparam int unsigned MacBW  = 16;
  localparam int unsigned AccW   = MacAW + MacBW;

  // baseline filter weights, 8 fraction bits
  localparam logic [MacBW-1:0] BaseKeepWt = 16'd230;
  localparam logic [MacBW-1:0] BaseNewWt  = 16'd6656;  // 26 * 256
  localparam logic [BaseW-1:0] BaseReset  = 25'd65536; // 1 g

  localparam logic [CfgW-1:0] WinLenReset  = 16'd250;
  localparam logic [CfgW-1:0] HoldReset    = 16'd1000;
  localparam logic [CfgW-1:0] StatLimReset = 16'd51;
  localparam logic [CfgW-1:0] WalkLimReset = 16'd384;
  localparam logic [CfgW-1:0] RunLimReset  = 16'd768;

  typedef enum logic [2:0] {
    CFG_WINDOW_LEN = 3'd0,
    CFG_HOLD_TIME  = 3'd1,
    CFG_STAT_LIM   = 3'd2,
    CFG_WALK_LIM   = 3'd3,
    CFG_RUN_LIM    = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    LVL_STATIONARY = 2'd0,
    LVL_WALKING    = 2'd1,
    LVL_RUNNING    = 2'd2,
    LVL_SPRINTING  = 2'd3
  } level_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_RINIT,
    ST_ROOT,
    ST_ACCUM,
    ST_DIV,
    ST_BASE,
    ST_DEV,
    ST_LEVEL,
    ST_HOLD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic en;
    logic clr;
  } mac_ctrl_t;

endpackage

// ===== sv/accel_activity_level_classifier.sv =====
// ----------------------------------------------------------------------------
// Accelerometer activity level classifier
// Window-averaged vector magnitude against a gravity baseline, four levels.
// ----------------------------------------------------------------------------
// One word in, one word out. Each sample gets |a| = floor(sqrt(x^2+y^2+z^2))
// added to a window sum; when window_length_ms has elapsed the window average
// updates a gravity baseline (230/256 old, 26/256 new) and the rounded
// deviation is graded into levels 0..3. Higher levels apply at once, lower
// ones only after hold_time_ms. The block handles one sample at a time and
// keeps in_stall_o high until its result word is written; a sample that
// closes the window also runs the divide and baseline steps. The sum is
// SUM_W = 16 + clog2(MAX_WINDOW_SAMPLES + 1) bits. The work uses one shared
// multiplier (3 squares, 2 baseline products), 16 square-root steps and
// SUM_W restoring divide steps that share one compare-subtract. The result
// sits in an output register, so a new sample is taken while it waits.
// Configuration writes are accepted at any time (cfg_ready_o is tied high)
// but must only be issued while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module accel_activity_level_classifier #(
  parameter int unsigned MAX_WINDOW_SAMPLES = aalc_pkg::MaxWindowSamplesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [2:0]                   cfg_index_i,
  input  logic [aalc_pkg::CfgW-1:0]    cfg_data_i,
  // sample channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [aalc_pkg::AxisW-1:0] accel_x_i,
  input  logic signed [aalc_pkg::AxisW-1:0] accel_y_i,
  input  logic signed [aalc_pkg::AxisW-1:0] accel_z_i,
  input  logic [aalc_pkg::TimeW-1:0]   time_ms_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         level_valid_o,
  output logic [1:0]                   activity_level_o,
  output logic [15:0]                  motion_strength_o,
  output logic                         led_red_o,
  output logic                         led_yellow_o,
  output logic                         led_green_o
);
  import aalc_pkg::*;

  // count must hold MAX itself; sum holds MAX full-scale magnitudes
  localparam int unsigned CntW  = $clog2(MAX_WINDOW_SAMPLES + 1);
  localparam int unsigned SumW  = MagW + CntW;
  // shared compare-subtract: sqrt remainder needs 20 bits, divide CntW+2
  localparam int unsigned CsW   = (CntW + 2 > 20) ? CntW + 2 : 20;
  localparam int unsigned StepW = $clog2(SumW + 1);

  localparam logic [CntW-1:0] CntMax = CntW'(MAX_WINDOW_SAMPLES);

  // ---------------- config registers ----------------
  logic [CfgW-1:0] win_len_q, hold_q, stat_lim_q, walk_lim_q, run_lim_q;
  logic            cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q  <= WinLenReset;
      hold_q     <= HoldReset;
      stat_lim_q <= StatLimReset;
      walk_lim_q <= WalkLimReset;
      run_lim_q  <= RunLimReset;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_WINDOW_LEN: win_len_q  <= cfg_data_i;
        CFG_HOLD_TIME:  hold_q     <= cfg_data_i;
        CFG_STAT_LIM:   stat_lim_q <= cfg_data_i;
        CFG_WALK_LIM:   walk_lim_q <= cfg_data_i;
        CFG_RUN_LIM:    run_lim_q  <= cfg_data_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------- state ----------------
  state_e state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             step_last;

  // captured sample
  logic [AxisW-1:0] x_q, y_q, z_q, x_d, y_d, z_d;
  logic [TimeW-1:0] now_q, now_d;

  // window and classifier state
  logic [SumW-1:0]  sum_q, sum_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [TimeW-1:0] wstart_q, wstart_d;
  logic [BaseW-1:0] base_q, base_d;
  logic [1:0]       cur_q, cur_d, pend_q, pend_d;
  logic [TimeW-1:0] lct_q, lct_d;

  // iteration registers
  logic [31:0]      n_q, n_d;
  logic [MagW-1:0]  root_q, root_d;
  logic [CsW-1:0]   rem_q, rem_d;
  logic [SumW-1:0]  div_q, div_d;     // dividend in, quotient out
  logic [CntW-1:0]  den_q, den_d;
  logic [15:0]      strength_q, strength_d;
  logic             closed_q, closed_d;

  // output word
  logic             out_valid_q, out_valid_d;
  logic             lv_q, lv_d;
  logic [1:0]       lvl_out_q, lvl_out_d;
  logic [15:0]      ms_q, ms_d;

  // shared multiplier
  mac_ctrl_t        mac_ctrl;
  logic [MacAW-1:0] mac_a;
  logic [MacBW-1:0] mac_b;
  logic [AccW-1:0]  acc;

  aalc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc)
  );

  // shared compare-subtract (sqrt and divide)
  logic [CsW-1:0] cs_a, cs_b;
  logic [CsW:0]   cs_diff;
  logic           cs_ge;

  assign cs_diff = {1'b0, cs_a} - {1'b0, cs_b};
  assign cs_ge   = !cs_diff[CsW];

  // misc datapath terms
  logic [AxisW-1:0] abs_sel, ax_sel;
  logic [15:0]      avg;
  logic             full, elapsed;
  logic [SumW-1:0]  sum_new;
  logic [CntW-1:0]  cnt_new;
  logic [AccW-1:0]  acc_rnd;
  logic [BaseW-1:0] scaled, dev;
  logic [BaseW:0]   dev_rnd;
  logic [1:0]       lvl, cur_t, pend_t;
  logic             up, chg, hold_ok;

  assign in_stall_o = (state_q != ST_IDLE);
  assign avg        = div_q[15:0];  // quotient never exceeds max magnitude

  // per-state step limit
  always_comb begin
    step_last = 1'b1;
    unique case (state_q)
      ST_SQ:   step_last = (step_q == StepW'(2));
      ST_ROOT: step_last = (step_q == StepW'(MagW - 1));
      ST_DIV:  step_last = (step_q == StepW'(SumW - 1));
      ST_BASE: step_last = (step_q == StepW'(1));
      default: step_last = 1'b1;
    endcase
  end

  // accumulate / window-close test
  assign full    = (cnt_q >= CntMax);
  assign sum_new = full ? sum_q : sum_q + SumW'(root_q);
  assign cnt_new = full ? cnt_q : cnt_q + 1'b1;
  assign elapsed = (now_q - wstart_q) >= TimeW'(win_len_q);

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_SQ;
      ST_SQ:    if (step_last) state_d = ST_RINIT;
      ST_RINIT: state_d = ST_ROOT;
      ST_ROOT:  if (step_last) state_d = ST_ACCUM;
      ST_ACCUM: state_d = elapsed ? ST_DIV : ST_OUT;
      ST_DIV:   if (step_last) state_d = ST_BASE;
      ST_BASE:  if (step_last) state_d = ST_DEV;
      ST_DEV:   state_d = ST_LEVEL;
      ST_LEVEL: state_d = ST_HOLD;
      ST_HOLD:  state_d = ST_OUT;
      ST_OUT:   if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // ---------------- datapath / outputs ----------------
  always_comb begin
    step_d     = step_q;
    x_d        = x_q;
    y_d        = y_q;
    z_d        = z_q;
    now_d      = now_q;
    sum_d      = sum_q;
    cnt_d      = cnt_q;
    wstart_d   = wstart_q;
    base_d     = base_q;
    cur_d      = cur_q;
    pend_d     = pend_q;
    lct_d      = lct_q;
    n_d        = n_q;
    root_d     = root_q;
    rem_d      = rem_q;
    div_d      = div_q;
    den_d      = den_q;
    strength_d = strength_q;
    closed_d   = closed_q;
    lv_d       = lv_q;
    lvl_out_d  = lvl_out_q;
    ms_d       = ms_q;
    // result is gone once taken
    out_valid_d = out_valid_q && out_stall_i;

    mac_ctrl = '{en: 1'b0, clr: 1'b0};
    mac_a    = '0;
    mac_b    = '0;
    cs_a     = '0;
    cs_b     = '0;

    ax_sel = (step_q == StepW'(0)) ? x_q : ((step_q == StepW'(1)) ? y_q : z_q);
    abs_sel = ax_sel[AxisW-1] ? (~ax_sel + 1'b1) : ax_sel;

    acc_rnd = acc + AccW'(128);
    scaled  = {1'b0, avg, 8'h00};
    dev     = (scaled >= base_q) ? scaled - base_q : base_q - scaled;
    dev_rnd = {1'b0, dev} + (BaseW + 1)'(128);

    // ordered limit tests
    if (strength_q < stat_lim_q)      lvl = LVL_STATIONARY;
    else if (strength_q < walk_lim_q) lvl = LVL_WALKING;
    else if (strength_q < run_lim_q)  lvl = LVL_RUNNING;
    else                              lvl = LVL_SPRINTING;

    up     = lvl > cur_q;
    chg    = up || (lvl != pend_q);
    cur_t  = up ? lvl : cur_q;
    pend_t = chg ? lvl : pend_q;
    // a fresh change restarts the hold timer at zero elapsed
    hold_ok = chg ? (hold_q == '0) : ((now_q - lct_q) >= TimeW'(hold_q));

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          x_d    = accel_x_i;
          y_d    = accel_y_i;
          z_d    = accel_z_i;
          now_d  = time_ms_i;
          step_d = '0;
        end
      end
      ST_SQ: begin
        mac_ctrl = '{en: 1'b1, clr: (step_q == StepW'(0))};
        mac_a    = MacAW'(abs_sel);
        mac_b    = abs_sel;
        step_d   = step_last ? '0 : step_q + 1'b1;
      end
      ST_RINIT: begin
        n_d    = acc[31:0];
        root_d = '0;
        rem_d  = '0;
        step_d = '0;
      end
      ST_ROOT: begin
        // one result bit per step
        cs_a   = {rem_q[CsW-3:0], n_q[31:30]};
        cs_b   = CsW'({root_q, 2'b01});
        rem_d  = cs_ge ? cs_diff[CsW-1:0] : cs_a;
        root_d = {root_q[MagW-2:0], cs_ge};
        n_d    = {n_q[29:0], 2'b00};
        step_d = step_last ? '0 : step_q + 1'b1;
      end
      ST_ACCUM: begin
        if (elapsed) begin
          sum_d    = '0;
          cnt_d    = '0;
          wstart_d = now_q;
          div_d    = sum_new;
          den_d    = cnt_new;
          rem_d    = '0;
          closed_d = 1'b1;
        end else begin
          sum_d    = sum_new;
          cnt_d    = cnt_new;
          closed_d = 1'b0;
        end
        step_d = '0;
      end
      ST_DIV: begin
        // restoring divide, quotient shifts in behind the dividend
        cs_a   = {rem_q[CsW-2:0], div_q[SumW-1]};
        cs_b   = CsW'(den_q);
        rem_d  = cs_ge ? cs_diff[CsW-1:0] : cs_a;
        div_d  = {div_q[SumW-2:0], cs_ge};
        step_d = step_last ? '0 : step_q + 1'b1;
      end
      ST_BASE: begin
        if (step_q == StepW'(0)) begin
          mac_ctrl = '{en: 1'b1, clr: 1'b1};
          mac_a    = base_q;
          mac_b    = BaseKeepWt;
        end else begin
          mac_ctrl = '{en: 1'b1, clr: 1'b0};
          mac_a    = MacAW'(avg);
          mac_b    = BaseNewWt;
        end
        step_d = step_last ? '0 : step_q + 1'b1;
      end
      ST_DEV: begin
        base_d = acc_rnd[8 +: BaseW];
      end
      ST_LEVEL: begin
        strength_d = dev_rnd[23:8];
      end
      ST_HOLD: begin
        pend_d = pend_t;
        lct_d  = chg ? now_q : lct_q;
        cur_d  = ((lvl < cur_t) && hold_ok) ? pend_t : cur_t;
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          lv_d        = closed_q;
          lvl_out_d   = cur_q;
          ms_d        = closed_q ? strength_q : '0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
      cnt_q       <= '0;
      wstart_q    <= '0;
      base_q      <= BaseReset;
      cur_q       <= LVL_STATIONARY;
      pend_q      <= LVL_STATIONARY;
      lct_q       <= '0;
      closed_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      wstart_q    <= wstart_d;
      base_q      <= base_d;
      cur_q       <= cur_d;
      pend_q      <= pend_d;
      lct_q       <= lct_d;
      closed_q    <= closed_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    z_q        <= z_d;
    now_q      <= now_d;
    n_q        <= n_d;
    root_q     <= root_d;
    rem_q      <= rem_d;
    div_q      <= div_d;
    den_q      <= den_d;
    strength_q <= strength_d;
    lv_q       <= lv_d;
    lvl_out_q  <= lvl_out_d;
    ms_q       <= ms_d;
  end

  assign out_valid_o       = out_valid_q;
  assign level_valid_o     = lv_q;
  assign activity_level_o  = lvl_out_q;
  assign motion_strength_o = ms_q;
  // lamp pattern; level 3 lights all three
  assign led_red_o    = (lvl_out_q == LVL_STATIONARY) || (lvl_out_q == LVL_SPRINTING);
  assign led_yellow_o = (lvl_out_q == LVL_WALKING)    || (lvl_out_q == LVL_SPRINTING);
  assign led_green_o  = (lvl_out_q == LVL_RUNNING)    || (lvl_out_q == LVL_SPRINTING);

  // ---------------- assertions ----------------
`include "accel_activity_level_classifier_macros.svh"

  `AALC_ASSERT_NXT(a_accept_starts, in_valid_i && !in_stall_o, state_q == ST_SQ, "accept did not start work")
  `AALC_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CntMax, "sample count above window limit")
  `AALC_ASSERT_NXT(a_out_waits, state_q == ST_OUT && out_valid_q && out_stall_i, state_q == ST_OUT, "result word overwritten while stalled")
  `AALC_ASSERT_IMP(a_open_no_strength, out_valid_o && !level_valid_o, motion_strength_o == '0, "strength on open window")

endmodule

// ===== sv/aalc_mac.sv =====
// ----------------------------------------------------------------------------
// Activity level classifier multiply-accumulate
// Shared 25x16 multiplier feeding one accumulator register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aalc_mac (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  aalc_pkg::mac_ctrl_t         ctrl_i,
  input  logic [aalc_pkg::MacAW-1:0]  a_i,
  input  logic [aalc_pkg::MacBW-1:0]  b_i,
  output logic [aalc_pkg::AccW-1:0]   acc_o
);
  import aalc_pkg::*;

  logic [AccW-1:0] acc_q, acc_d, prod;

  assign prod  = AccW'(a_i) * AccW'(b_i);
  assign acc_d = (ctrl_i.clr ? '0 : acc_q) + prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== verif/accel_activity_level_classifier_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Activity level classifier testbench
// Drives timestamped acceleration words through the valid/stall sample port,
// predicts every result word from an in-bench fixed-point model of the
// window averaging, baseline filter, grading and hold logic, and checks each
// result word field by field in order. Both ports idle and stall at random.
// ----------------------------------------------------------------------------

module accel_activity_level_classifier_tb;
  import aalc_pkg::*;

  localparam int unsigned SampleCap    = MaxWindowSamplesDef;
  localparam int unsigned IdleMax      = 17;
  // margin over the time a closing sample holds the block
  localparam int unsigned SettleCycles = 64;
  localparam int unsigned ReportMax    = 10;
  localparam int unsigned SatSamples   = 1030;

  // one expected result word
  typedef struct {
    logic        closed;
    level_e      level;
    logic [15:0] strength;
    logic        red;
    logic        yellow;
    logic        green;
  } level_word_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = CFG_WINDOW_LEN;
  logic [CfgW-1:0]    cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] accel_x_i   = '0;
  logic signed [15:0] accel_y_i   = '0;
  logic signed [15:0] accel_z_i   = '0;
  logic [31:0]        time_ms_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               level_valid_o;
  logic [1:0]         activity_level_o;
  logic [15:0]        motion_strength_o;
  logic               led_red_o;
  logic               led_yellow_o;
  logic               led_green_o;

  always #4 clk_i = ~clk_i;

  accel_activity_level_classifier #(
    .MAX_WINDOW_SAMPLES(SampleCap)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .accel_x_i        (accel_x_i),
    .accel_y_i        (accel_y_i),
    .accel_z_i        (accel_z_i),
    .time_ms_i        (time_ms_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .level_valid_o    (level_valid_o),
    .activity_level_o (activity_level_o),
    .motion_strength_o(motion_strength_o),
    .led_red_o        (led_red_o),
    .led_yellow_o     (led_yellow_o),
    .led_green_o      (led_green_o)
  );

  // --------------------------------------------------------------------------
  // Predictor state: register copies and classifier state
  // --------------------------------------------------------------------------
  logic [15:0] win_len_ms    = WinLenReset;
  logic [15:0] hold_ms       = HoldReset;
  logic [15:0] stat_lim      = StatLimReset;
  logic [15:0] walk_lim      = WalkLimReset;
  logic [15:0] run_lim       = RunLimReset;

  logic [26:0] win_sum       = '0;
  logic [10:0] win_count     = '0;
  logic [31:0] win_start_ms  = '0;
  logic [24:0] baseline      = BaseReset;
  level_e      cur_level     = LVL_STATIONARY;
  level_e      pend_level    = LVL_STATIONARY;
  logic [31:0] change_ms     = '0;

  level_word_t level_words_due[$];
  int unsigned fail_count = 0;
  logic        idle_off   = 1'b0;   // set for stretches with no idling
  logic [31:0] clock_ms   = '0;     // time stamp of the last sent word

  // digit-by-digit integer square root
  function automatic logic [15:0] int_sqrt(input logic [31:0] n);
    logic [31:0] rem;
    logic [31:0] root;
    logic [31:0] probe;
    rem   = n;
    root  = '0;
    probe = 32'h4000_0000;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root[15:0];
  endfunction

  // limits are tried in turn, so unordered limits resolve to the first hit
  function automatic level_e grade(input logic [15:0] dev);
    if (dev < stat_lim) return LVL_STATIONARY;
    if (dev < walk_lim) return LVL_WALKING;
    if (dev < run_lim)  return LVL_RUNNING;
    return LVL_SPRINTING;
  endfunction

  function automatic level_word_t classify_sample(input logic signed [15:0] ax,
                                                  input logic signed [15:0] ay,
                                                  input logic signed [15:0] az,
                                                  input logic [31:0] now);
    logic [31:0] sq;
    logic [15:0] mag;
    logic [15:0] avg;
    logic [63:0] nb;
    logic [31:0] scaled;
    logic [31:0] diff;
    level_e      lvl;
    level_word_t w;
    sq = 32'(int'(ax) * int'(ax)) + 32'(int'(ay) * int'(ay)) + 32'(int'(az) * int'(az));
    mag = int_sqrt(sq);
    // full window: further samples are dropped from sum and count
    if (win_count < SampleCap) begin
      win_sum   = win_sum + 27'(mag);
      win_count = win_count + 11'd1;
    end
    w.closed   = 1'b0;
    w.strength = '0;
    // elapsed time modulo 2^32; zero length closes on every sample
    if (32'(now - win_start_ms) >= 32'(win_len_ms)) begin
      avg = (win_count != 0) ? 16'(win_sum / win_count) : 16'd256;
      win_sum      = '0;
      win_count    = '0;
      win_start_ms = now;
      nb = (64'(baseline) * 64'd230 + 64'(avg) * 64'd6656 + 64'd128) >> 8;
      baseline = nb[24:0];
      scaled = 32'(avg) << 8;
      diff = (scaled >= 32'(baseline)) ? scaled - 32'(baseline) : 32'(baseline) - scaled;
      w.strength = 16'((diff + 32'd128) >> 8);
      lvl = grade(w.strength);
      if (lvl > cur_level) begin
        cur_level  = lvl;
        pend_level = lvl;
        change_ms  = now;
      end else if (lvl != pend_level) begin
        pend_level = lvl;
        change_ms  = now;
      end
      if (lvl < cur_level && 32'(now - change_ms) >= 32'(hold_ms)) cur_level = pend_level;
      w.closed = 1'b1;
    end
    w.level  = cur_level;
    w.red    = (cur_level == LVL_STATIONARY) || (cur_level == LVL_SPRINTING);
    w.yellow = (cur_level == LVL_WALKING) || (cur_level == LVL_SPRINTING);
    w.green  = (cur_level == LVL_RUNNING) || (cur_level == LVL_SPRINTING);
    return w;
  endfunction

  task automatic flag_error(input string msg);
    fail_count++;
    if (fail_count <= ReportMax) $display("%s", msg);
  endtask

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // drop valid and hold off until every outstanding result word is back;
  // always waits for a clock edge so valid is never lowered and raised together
  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (level_words_due.size() != 0);
  endtask

  // writes all five registers, block idle
  task automatic set_config(input logic [15:0] win, input logic [15:0] hold,
                            input logic [15:0] stat, input logic [15:0] walk,
                            input logic [15:0] run);
    cfg_idx_e    idx_list[5] = '{CFG_WINDOW_LEN, CFG_HOLD_TIME, CFG_STAT_LIM,
                                 CFG_WALK_LIM, CFG_RUN_LIM};
    logic [15:0] vals[5];
    vals = '{win, hold, stat, walk, run};
    wait_results_done();
    for (int i = 0; i < 5; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx_list[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx_list[i])
        CFG_WINDOW_LEN: win_len_ms = vals[i];
        CFG_HOLD_TIME:  hold_ms    = vals[i];
        CFG_STAT_LIM:   stat_lim   = vals[i];
        CFG_WALK_LIM:   walk_lim   = vals[i];
        CFG_RUN_LIM:    run_lim    = vals[i];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // one sample word; valid stays high when the next word follows at once
  task automatic send_sample(input logic signed [15:0] ax, input logic signed [15:0] ay,
                             input logic signed [15:0] az, input logic [31:0] now);
    int unsigned gap;
    gap = idle_off ? 0 : $urandom_range(0, IdleMax);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    accel_x_i  <= ax;
    accel_y_i  <= ay;
    accel_z_i  <= az;
    time_ms_i  <= now;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    level_words_due.push_back(classify_sample(ax, ay, az, now));
    clock_ms = now;
  endtask

  // roughly 1 g along a random axis with jitter of +-amp on every axis
  task automatic pick_gravity(input int amp, output logic signed [15:0] ax,
                              output logic signed [15:0] ay, output logic signed [15:0] az);
    int v[3];
    int axis;
    axis = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) v[i] = int'($urandom_range(0, 2 * amp)) - amp;
    v[axis] = v[axis] + ($urandom_range(0, 1) ? 256 : -256);
    ax = 16'(v[0]);
    ay = 16'(v[1]);
    az = 16'(v[2]);
  endtask

  // --------------------------------------------------------------------------
  // Result checker: random stalls, compares each word with the oldest
  // expectation
  // --------------------------------------------------------------------------
  initial begin : result_checker
    level_word_t want;
    logic        bad;
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      gap = idle_off ? 0 : $urandom_range(0, IdleMax);
      if (gap != 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      if (level_words_due.size() == 0) begin
        flag_error($sformatf("%0t: result word with no expectation", $realtime));
      end else begin
        want = level_words_due.pop_front();
        bad = (level_valid_o     !== want.closed)   ||
              (activity_level_o  !== want.level)    ||
              (motion_strength_o !== want.strength) ||
              (led_red_o         !== want.red)      ||
              (led_yellow_o      !== want.yellow)   ||
              (led_green_o       !== want.green);
        if (bad) begin
          flag_error($sformatf(
            "%0t: mismatch exp valid=%0d lvl=%0d str=%0d led=%b%b%b got valid=%0d lvl=%0d str=%0d led=%b%b%b",
            $realtime, want.closed, want.level, want.strength, want.red, want.yellow,
            want.green, level_valid_o, activity_level_o, motion_strength_o, led_red_o,
            led_yellow_o, led_green_o));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------
  // reset registers: the first words stay red until a 250 ms window closes
  task automatic test_reset_defaults();
    send_sample(16'sd0, 16'sd0, 16'sd256, 32'd0);
    send_sample(16'sd10, -16'sd20, 16'sd250, 32'd100);
    send_sample(16'sd0, 16'sd0, 16'sd256, 32'd250);
  endtask

  // zero window length, zero hold; largest and smallest vectors
  task automatic test_axis_extremes();
    set_config(16'd0, 16'd0, StatLimReset, WalkLimReset, RunLimReset);
    send_sample(-16'sd32768, -16'sd32768, -16'sd32768, clock_ms + 1);
    send_sample(16'sd32767, 16'sd32767, 16'sd32767, clock_ms + 1);
    send_sample(16'sd0, 16'sd0, 16'sd0, clock_ms + 1);
    send_sample(-16'sd32768, 16'sd32767, 16'sd0, clock_ms);
    send_sample(-16'sd1, -16'sd1, -16'sd1, clock_ms + 3);
  endtask

  // unordered and extreme limits
  task automatic test_limit_order();
    set_config(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0);
    send_sample(16'sd0, 16'sd3000, 16'sd0, clock_ms + 1);
    send_sample(16'sd0, 16'sd0, 16'sd256, clock_ms + 1);
    set_config(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0);
    send_sample(16'sd900, 16'sd0, 16'sd0, clock_ms + 1);
    set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
    send_sample(16'sd0, 16'sd0, -16'sd256, clock_ms + 1);
    set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_sample(16'sd0, 16'sd0, 16'sd256, clock_ms + 1);
  endtask

  // jump to a high level at once, fall back only after the hold time
  task automatic test_hold_behavior();
    logic [31:0] t0;
    set_config(16'd0, 16'd10, StatLimReset, WalkLimReset, RunLimReset);
    t0 = clock_ms + 50;
    send_sample(16'sd0, 16'sd0, 16'sd4000, t0);
    send_sample(16'sd0, 16'sd0, 16'sd256, t0 + 1);
    send_sample(16'sd0, 16'sd0, 16'sd256, t0 + 5);
    send_sample(16'sd0, 16'sd0, 16'sd256, t0 + 12);
    send_sample(16'sd0, 16'sd0, 16'sd256, t0 + 13);
  endtask

  // window and hold across the 2^32 ms wrap
  task automatic test_time_wrap();
    set_config(16'd100, 16'hFFFF, StatLimReset, WalkLimReset, RunLimReset);
    send_sample(16'sd0, 16'sd2000, 16'sd0, 32'hFFFF_FFC0);
    send_sample(16'sd0, 16'sd256, 16'sd0, 32'hFFFF_FFF0);
    send_sample(16'sd0, 16'sd256, 16'sd0, 32'h0000_0030);
  endtask

  // more than SampleCap samples in one 65535 ms window
  task automatic test_count_saturation();
    logic signed [15:0] ax, ay, az;
    logic [31:0] t0;
    logic [31:0] now;
    int amp;
    // close a window now so the long one starts from a known time
    set_config(16'd0, 16'($urandom_range(0, 2000)), StatLimReset, WalkLimReset, RunLimReset);
    send_sample(16'sd0, 16'sd0, 16'sd256, clock_ms + 7);
    t0 = clock_ms;
    set_config(16'hFFFF, hold_ms, StatLimReset, WalkLimReset, RunLimReset);
    amp = 40;
    for (int i = 0; i < SatSamples; i++) begin
      idle_off = (i < 300);
      if (i % 64 == 0) amp = $urandom_range(0, 1500);
      now = clock_ms + $urandom_range(0, 60);
      if (32'(now - t0) >= 32'd65000) now = clock_ms;
      if ($urandom_range(0, 29) == 0) begin
        ax = 16'($urandom());
        ay = 16'($urandom());
        az = 16'($urandom());
      end else begin
        pick_gravity(amp, ax, ay, az);
      end
      send_sample(ax, ay, az, now);
    end
    idle_off = 1'b0;
    // exactly one window length later: closes
    send_sample(16'sd0, 16'sd0, 16'sd256, t0 + 32'd65535);
  endtask

  // --------------------------------------------------------------------------
  // Random phases: new registers each phase, mostly gravity-like motion with
  // changing intensity, some raw noise and time jumps
  // --------------------------------------------------------------------------
  task automatic run_motion(input int count, input int unsigned max_step);
    int amps[5] = '{4, 40, 150, 400, 1200};
    int amp;
    logic signed [15:0] ax, ay, az;
    logic [31:0] now;
    amp = 4;
    for (int i = 0; i < count; i++) begin
      if (i % 8 == 0) amp = amps[$urandom_range(0, 4)];
      // sender holds off until the block has handed back everything
      if ($urandom_range(0, 39) == 0) wait_results_done();
      if ($urandom_range(0, 24) == 0) now = $urandom();
      else now = clock_ms + $urandom_range(0, max_step);
      if ($urandom_range(0, 19) == 0) begin
        ax = 16'($urandom());
        ay = 16'($urandom());
        az = 16'($urandom());
      end else begin
        pick_gravity(amp, ax, ay, az);
      end
      send_sample(ax, ay, az, now);
    end
  endtask

  task automatic test_random_phases();
    logic [15:0] win, hold, stat, walk, run;
    int unsigned max_step;
    for (int p = 0; p < 10; p++) begin
      case ($urandom_range(0, 9))
        0:       win = 16'd0;
        1:       win = 16'd1;
        2:       win = 16'hFFFF;
        default: win = 16'($urandom_range(2, 80));
      endcase
      case ($urandom_range(0, 5))
        0:       hold = 16'd0;
        1:       hold = 16'hFFFF;
        default: hold = 16'($urandom_range(1, 300));
      endcase
      case ($urandom_range(0, 3))
        0: begin
          stat = StatLimReset;
          walk = WalkLimReset;
          run  = RunLimReset;
        end
        1: begin
          stat = 16'($urandom_range(0, 200));
          walk = stat + 16'($urandom_range(0, 500));
          run  = walk + 16'($urandom_range(0, 1000));
        end
        2: begin
          stat = 16'($urandom());
          walk = 16'($urandom());
          run  = 16'($urandom());
        end
        default: begin
          stat = 16'($urandom_range(0, 1500));
          walk = 16'($urandom_range(0, 1500));
          run  = 16'($urandom_range(0, 1500));
        end
      endcase
      set_config(win, hold, stat, walk, run);
      if (win == 16'hFFFF) max_step = 4000;
      else if (win == 16'd0) max_step = 5;
      else max_step = win / 3 + 1;
      idle_off = (p % 4 == 3);
      run_motion(32, max_step);
    end
    idle_off = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_axis_extremes();
    test_limit_order();
    test_hold_behavior();
    test_time_wrap();
    test_count_saturation();
    test_random_phases();
    wait_results_done();
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("accel_activity_level_classifier_tb: PASS");
    end else begin
      $display("accel_activity_level_classifier_tb: FAIL");
    end
    $finish;
  end

  // run guard, several times the slowest legal run
  initial begin : run_guard
    #6_000_000;
    $display("accel_activity_level_classifier_tb: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/aalc_pkg.sv
sv/aalc_mac.sv
sv/accel_activity_level_classifier.sv
verif/accel_activity_level_classifier_tb.sv
